/* hw/rtl/lob_pkg.sv */
`timescale 1ns / 1ps
package lob_pkg;

  localparam int SLOTS   = 32;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int REM_W   = QTY_W - 1;
  localparam int ID_W    = 32;
  localparam int ARR_W   = 32;
  localparam int SUM_W   = REM_W + SLOT_W;

  typedef enum logic [1:0] {
    CMD_SUBMIT  = 2'd0,
    CMD_CANCEL  = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    TIF_GTC  = 2'd0,
    TIF_IOC  = 2'd1,
    TIF_FOK  = 2'd2,
    TIF_RSVD = 2'd3
  } tif_t;

  typedef enum logic [2:0] {
    REJ_NONE       = 3'd0,
    REJ_NO_LIQ     = 3'd1,
    REJ_POST_CROSS = 3'd2,
    REJ_NOT_FOUND  = 3'd3,
    REJ_BAD_QTY    = 3'd4,
    REJ_DUP        = 3'd5,
    REJ_FULL       = 3'd6,
    REJ_RSVD       = 3'd7
  } rej_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_step;
    logic drop_found;
    logic bump_arrival;
    logic apply_fill;
    logic write_slot;
    logic emit_fill;
    logic emit_status;
    logic acc;
    logic rest;
    logic full;
    logic canc;
    rej_t rej;
  } lob_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic qty_bad;
    logic scan_last;
    logic found;
    logic cross_any;
    logic fok_short;
    logic best_found;
    logic taker_done;
    logic rem_zero;
    logic free_found;
    logic tif_kill;
    logic is_fok;
    logic post_only;
  } lob_stat_t;

endpackage

/* hw/rtl/lob_datapath.sv */
`timescale 1ns / 1ps
module lob_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [1:0]                           cmd,
  input  logic [lob_pkg::ID_W-1:0]             order_id,
  input  logic                                 side,
  input  logic signed [lob_pkg::PRICE_W-1:0]   price,
  input  logic signed [lob_pkg::QTY_W-1:0]     quantity,
  input  logic [1:0]                           tif,
  input  logic                                 post_only,
  input  lob_pkg::lob_ctrl_t                   ctrl,
  output lob_pkg::lob_stat_t                   stat,
  output logic                                 valid,
  output logic                                 kind,
  output logic [lob_pkg::ID_W-1:0]             maker_order_id,
  output logic [lob_pkg::REM_W-1:0]            fill_qty,
  output logic signed [lob_pkg::PRICE_W-1:0]   fill_price,
  output logic                                 accepted,
  output logic                                 resting,
  output logic                                 filled,
  output logic                                 cancelled,
  output logic [2:0]                           rej_code,
  output logic                                 last
);
  import lob_pkg::*;

  // Slot storage.
  logic [SLOTS-1:0]                 slot_valid;
  logic                             slot_side      [SLOTS];
  logic signed [PRICE_W-1:0]        slot_price     [SLOTS];
  logic [REM_W-1:0]                 slot_remaining [SLOTS];
  logic [ID_W-1:0]                  slot_owner_id  [SLOTS];
  logic [ARR_W-1:0]                 slot_arrival   [SLOTS];
  logic [ARR_W-1:0]                 arrival_counter;

  // Latched command.
  cmd_t                      cmd_q;
  logic [ID_W-1:0]           id_q;
  logic                      side_q;
  logic signed [PRICE_W-1:0] price_q;
  logic signed [QTY_W-1:0]   qty_q;
  tif_t                      tif_q;
  logic                      post_q;
  logic [REM_W-1:0]          rem;
  logic [ARR_W-1:0]          arr_q;

  // Scan accumulators.
  logic [SLOT_W-1:0]         idx;
  logic                      found;
  logic [SLOT_W-1:0]         found_idx;
  logic                      found_side;
  logic                      free_found;
  logic [SLOT_W-1:0]         free_idx;
  logic                      cross_any;
  logic [SUM_W-1:0]          fok_total;
  logic                      best_found;
  logic [SLOT_W-1:0]         best_idx;
  logic signed [PRICE_W-1:0] best_px;
  logic [ARR_W-1:0]          best_age;
  logic [REM_W-1:0]          best_rem;
  logic [ID_W-1:0]           best_id;

  logic                      cur_valid;
  logic                      cur_side;
  logic signed [PRICE_W-1:0] cur_price;
  logic [REM_W-1:0]          cur_rem;
  logic [ID_W-1:0]           cur_id;
  logic [ARR_W-1:0]          cur_age;
  logic                      crosses;
  logic                      cand;
  logic                      better;
  logic [REM_W-1:0]          traded;

  // Slot under scan, read at the scan index only.
  assign cur_valid = slot_valid[idx];
  assign cur_side  = slot_side[idx];
  assign cur_price = slot_price[idx];
  assign cur_rem   = slot_remaining[idx];
  assign cur_id    = slot_owner_id[idx];
  assign cur_age   = arrival_counter - slot_arrival[idx];

  // A resting order on the other side whose price crosses the taker limit.
  always_comb begin
    crosses = side_q ? (cur_price >= price_q) : (cur_price <= price_q);
    cand    = cur_valid && (cur_side != side_q) && crosses;
    if (!best_found) begin
      better = 1'b1;
    end else if (cur_price != best_px) begin
      better = side_q ? (cur_price > best_px) : (cur_price < best_px);
    end else begin
      better = cur_age > best_age;
    end
  end

  assign traded = (rem < best_rem) ? rem : best_rem;

  always_comb begin
    stat            = '0;
    stat.cmd        = cmd_q;
    stat.qty_bad    = (qty_q <= 0);
    stat.scan_last  = (idx == SLOT_W'(SLOTS - 1));
    stat.found      = found;
    stat.cross_any  = cross_any;
    stat.fok_short  = fok_total < SUM_W'(rem);
    stat.best_found = best_found;
    stat.taker_done = (rem <= best_rem);
    stat.rem_zero   = (rem == '0);
    stat.free_found = free_found;
    stat.tif_kill   = (tif_q == TIF_IOC) || (tif_q == TIF_FOK);
    stat.is_fok     = (tif_q == TIF_FOK);
    stat.post_only  = post_q;
  end

  // Command latch and taker state.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= cmd_t'(cmd);
      id_q    <= order_id;
      side_q  <= side;
      price_q <= price;
      qty_q   <= quantity;
      tif_q   <= (tif_t'(tif) == TIF_RSVD) ? TIF_GTC : tif_t'(tif);
      post_q  <= post_only;
      rem     <= quantity[REM_W-1:0];
    end else begin
      if (ctrl.drop_found) begin
        side_q <= found_side;
      end
      if (ctrl.apply_fill) begin
        rem <= rem - traded;
      end
    end
  end

  // Scan over the slots, one slot per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.scan_clear) begin
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      cross_any  <= 1'b0;
      fok_total  <= '0;
      best_found <= 1'b0;
    end else if (ctrl.scan_step) begin
      idx <= idx + 1'b1;
      if (!found && cur_valid && (cur_id == id_q)) begin
        found      <= 1'b1;
        found_idx  <= idx;
        found_side <= cur_side;
      end
      if (!free_found && !cur_valid) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (cand) begin
        cross_any <= 1'b1;
        fok_total <= fok_total + SUM_W'(cur_rem);
      end
      if (cand && better) begin
        best_found <= 1'b1;
        best_idx   <= idx;
        best_px    <= cur_price;
        best_age   <= cur_age;
        best_rem   <= cur_rem;
        best_id    <= cur_id;
      end
    end
  end

  // Book updates: valid bits and the arrival counter are control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      arrival_counter <= '0;
    end else begin
      if (ctrl.drop_found) begin
        slot_valid[found_idx] <= 1'b0;
      end
      if (ctrl.bump_arrival) begin
        arrival_counter <= arrival_counter + 1'b1;
      end
      if (ctrl.apply_fill && (traded == best_rem)) begin
        slot_valid[best_idx] <= 1'b0;
      end
      if (ctrl.write_slot) begin
        slot_valid[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.bump_arrival) begin
      arr_q <= arrival_counter;
    end
    if (ctrl.apply_fill) begin
      slot_remaining[best_idx] <= best_rem - traded;
    end
    if (ctrl.write_slot) begin
      slot_side[free_idx]      <= side_q;
      slot_price[free_idx]     <= price_q;
      slot_remaining[free_idx] <= rem;
      slot_owner_id[free_idx]  <= id_q;
      slot_arrival[free_idx]   <= arr_q;
    end
  end

  // Result register: each transfer is shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctrl.emit_fill || ctrl.emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_fill) begin
      kind           <= 1'b0;
      maker_order_id <= best_id;
      fill_qty       <= traded;
      fill_price     <= best_px;
      accepted       <= 1'b0;
      resting        <= 1'b0;
      filled         <= 1'b0;
      cancelled      <= 1'b0;
      rej_code       <= REJ_NONE;
      last           <= 1'b0;
    end else if (ctrl.emit_status) begin
      kind           <= 1'b1;
      maker_order_id <= '0;
      fill_qty       <= '0;
      fill_price     <= '0;
      accepted       <= ctrl.acc;
      resting        <= ctrl.rest;
      filled         <= ctrl.full;
      cancelled      <= ctrl.canc;
      rej_code       <= ctrl.rej;
      last           <= 1'b1;
    end
  end

endmodule

/* hw/rtl/lob_controller.sv */
`timescale 1ns / 1ps
module lob_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lob_pkg::lob_stat_t stat,
  output lob_pkg::lob_ctrl_t ctrl
);
  import lob_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_FIND_DONE,
    S_CHECK,
    S_CHECK_DONE,
    S_BEST,
    S_BEST_DONE,
    S_FINISH,
    S_PLACE,
    S_PLACE_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.rej   = REJ_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load       = 1'b1;
          ctrl.scan_clear = 1'b1;
          state_next      = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_SUBMIT: begin
            if (stat.qty_bad) begin
              ctrl.emit_status = 1'b1;
              ctrl.rej         = REJ_BAD_QTY;
              state_next       = S_IDLE;
            end else begin
              state_next = S_CHECK;
            end
          end
          CMD_CANCEL, CMD_REPLACE: begin
            state_next = S_FIND;
          end
          default: begin
            ctrl.emit_status = 1'b1;
            state_next       = S_IDLE;
          end
        endcase
      end
      S_FIND: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_FIND_DONE;
        end
      end
      S_FIND_DONE: begin
        if (!stat.found) begin
          ctrl.emit_status = 1'b1;
          ctrl.rej         = REJ_NOT_FOUND;
          state_next       = S_IDLE;
        end else if (stat.cmd == CMD_CANCEL) begin
          ctrl.drop_found  = 1'b1;
          ctrl.emit_status = 1'b1;
          ctrl.canc        = 1'b1;
          state_next       = S_IDLE;
        end else if (stat.qty_bad) begin
          ctrl.emit_status = 1'b1;
          ctrl.rej         = REJ_BAD_QTY;
          state_next       = S_IDLE;
        end else begin
          ctrl.drop_found = 1'b1;
          ctrl.scan_clear = 1'b1;
          state_next      = S_CHECK;
        end
      end
      S_CHECK: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_CHECK_DONE;
        end
      end
      S_CHECK_DONE: begin
        if (stat.post_only && stat.cross_any) begin
          ctrl.emit_status = 1'b1;
          ctrl.rej         = REJ_POST_CROSS;
          state_next       = S_IDLE;
        end else if (stat.is_fok && stat.fok_short) begin
          ctrl.emit_status = 1'b1;
          ctrl.rej         = REJ_NO_LIQ;
          state_next       = S_IDLE;
        end else begin
          ctrl.bump_arrival = 1'b1;
          ctrl.scan_clear   = 1'b1;
          state_next        = S_BEST;
        end
      end
      S_BEST: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_BEST_DONE;
        end
      end
      S_BEST_DONE: begin
        if (stat.best_found) begin
          ctrl.apply_fill = 1'b1;
          ctrl.emit_fill  = 1'b1;
          if (stat.taker_done) begin
            state_next = S_FINISH;
          end else begin
            ctrl.scan_clear = 1'b1;
            state_next      = S_BEST;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.rem_zero) begin
          ctrl.emit_status = 1'b1;
          ctrl.acc         = 1'b1;
          ctrl.full        = 1'b1;
          state_next       = S_IDLE;
        end else if (stat.tif_kill) begin
          ctrl.emit_status = 1'b1;
          ctrl.acc         = 1'b1;
          state_next       = S_IDLE;
        end else begin
          ctrl.scan_clear = 1'b1;
          state_next      = S_PLACE;
        end
      end
      S_PLACE: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_PLACE_DONE;
        end
      end
      S_PLACE_DONE: begin
        ctrl.emit_status = 1'b1;
        state_next       = S_IDLE;
        if (stat.found) begin
          ctrl.rej = REJ_DUP;
        end else if (!stat.free_found) begin
          ctrl.rej = REJ_FULL;
        end else begin
          ctrl.write_slot = 1'b1;
          ctrl.acc        = 1'b1;
          ctrl.rest       = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and registered busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

/* hw/rtl/limit_order_book_matcher.sv */
`timescale 1ns / 1ps
// Order book of one market with price-time priority over 32 resting slots.
// A command is transferred at a clock edge where start is high and busy is
// low; every result of that command then appears on the result ports for
// exactly one cycle with valid high, fills first and the status item (last
// high) at the end. The receiver cannot stall, so it must take each result
// in the cycle it is shown. The slots are examined one per cycle; each
// pass over the book is a scan of all 32 slots followed by a decision state.
// Every command starts with a decode state. A cancel adds one lookup pass.
// A submit adds a check pass, one search pass for each fill plus one more
// unless a fill completes the taker, a finish state, and one more pass if
// the remainder rests. A replace puts the lookup pass in front of that.
// A reject ends the command at the pass that finds it. busy drops in the
// cycle the status item is shown, and the next command can be transferred
// at the end of that cycle.
module limit_order_book_matcher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd,
  input  logic [lob_pkg::ID_W-1:0]            order_id,
  input  logic                                side,
  input  logic signed [lob_pkg::PRICE_W-1:0]  price,
  input  logic signed [lob_pkg::QTY_W-1:0]    quantity,
  input  logic [1:0]                          tif,
  input  logic                                post_only,
  output logic                                valid,
  output logic                                kind,
  output logic [lob_pkg::ID_W-1:0]            maker_order_id,
  output logic [lob_pkg::REM_W-1:0]           fill_qty,
  output logic signed [lob_pkg::PRICE_W-1:0]  fill_price,
  output logic                                accepted,
  output logic                                resting,
  output logic                                filled,
  output logic                                cancelled,
  output logic [2:0]                          rej_code,
  output logic                                last
);
  import lob_pkg::*;

  lob_ctrl_t ctrl;
  lob_stat_t stat;

  lob_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  lob_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .order_id       (order_id),
    .side           (side),
    .price          (price),
    .quantity       (quantity),
    .tif            (tif),
    .post_only      (post_only),
    .ctrl           (ctrl),
    .stat           (stat),
    .valid          (valid),
    .kind           (kind),
    .maker_order_id (maker_order_id),
    .fill_qty       (fill_qty),
    .fill_price     (fill_price),
    .accepted       (accepted),
    .resting        (resting),
    .filled         (filled),
    .cancelled      (cancelled),
    .rej_code       (rej_code),
    .last           (last)
  );

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after a command transfer");

  // Fills are only produced while the command is still being worked on.
  a_fill_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !kind |-> busy)
    else $error("fill shown while block is idle");

  // A rejected command is never reported as accepted.
  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    valid && kind && (rej_code != REJ_NONE) |-> !accepted && !resting)
    else $error("reject reported together with acceptance");

  // A status item ends the command, so busy is already low while it is shown.
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !busy)
    else $error("status item shown while command still running");

endmodule
